/* rtl/core/ppq_pkg.sv */
// Shared constants, codes and types of the priority task queue.
`timescale 1ns / 1ps

package ppq_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_DEPTH  = 8;

  localparam int QA_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NA_W   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int NL_W   = $clog2(NEST_DEPTH + 1);

  // field widths
  localparam int FUNC_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 3;
  localparam int PEND_W   = 5;

  localparam logic [PRIO_W-1:0] IDLE_RESET = 16'd9999;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DISP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DONE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd4;

  // queue store write request
  typedef struct packed {
    logic                en;
    logic [QA_W-1:0]     addr;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } qwr_t;

endpackage

/* rtl/core/ppq_channels.sv */
// Handshake channel interfaces: request, result and configuration write.
`timescale 1ns / 1ps

interface ppq_req_if import ppq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [HANDLE_W-1:0] task_handle;
  logic [PRIO_W-1:0]   task_priority;

  modport source (output valid, func, task_handle, task_priority, input ready);
  modport sink   (input valid, func, task_handle, task_priority, output ready);
endinterface

interface ppq_res_if import ppq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                dispatched;
  logic [HANDLE_W-1:0] out_handle;
  logic [PRIO_W-1:0]   out_priority;
  logic [PRIO_W-1:0]   running_priority_now;
  logic [PEND_W-1:0]   pending_count;

  modport source (output valid, status, dispatched, out_handle, out_priority,
                  running_priority_now, pending_count, input ready);
  modport sink   (input valid, status, dispatched, out_handle, out_priority,
                  running_priority_now, pending_count, output ready);
endinterface

interface ppq_cfg_if import ppq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRIO_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/ppq_queue_mem.sv */
// Task queue store: one write port, one read port with registered data.
`timescale 1ns / 1ps

module ppq_queue_mem import ppq_pkg::*; (
  input  logic                clk,
  input  qwr_t                wr,
  input  logic [QA_W-1:0]     rd_addr,
  output logic [PRIO_W-1:0]   rd_prio,
  output logic [HANDLE_W-1:0] rd_handle
);

  logic [PRIO_W-1:0]   prio_mem   [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] handle_mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      prio_mem[wr.addr]   <= wr.prio;
      handle_mem[wr.addr] <= wr.handle;
    end
    rd_prio   <= prio_mem[rd_addr];
    rd_handle <= handle_mem[rd_addr];
  end

endmodule

/* rtl/core/preemptive_priority_task_queue_unit.sv */
// Top level: preemptive priority task queue with nesting stack.
//
//   channel  dir  payload                                        transfer when
//   request  in   func, task_handle, task_priority               valid & ready
//   result   out  status, dispatched, out_handle, out_priority,  valid & ready
//                 running_priority_now, pending_count
//   cfg      in   data (idle priority)                           valid & ready
//
// After acceptance: a full enqueue, an empty-queue dispatch, underflow and unused
// codes go straight to the result; complete restores the saved priority; an
// enqueue into an empty queue writes the head, else the tail is read and the queue
// store walked towards the head one entry per cycle, moving entries up until the
// new task is placed; dispatch checks the head and, if eligible with stack room,
// pops it and shifts the rest down. request.ready returns with result.valid.
// Reset (rst, synchronous): queue and nesting stack empty, idle priority 9999.
// request.ready is high only while the sequencer idles; a result stalled on
// result.ready holds the sequencer in its final step. cfg is always ready.
`timescale 1ns / 1ps

module preemptive_priority_task_queue_unit import ppq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ppq_req_if.sink   request,
  ppq_res_if.source result,
  ppq_cfg_if.sink   cfg
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ_RD,    // read the tail entry
    S_ENQ_STEP,  // compare one entry, shift it up or place the new task
    S_ENQ_INS,   // place the new task at the head
    S_DSP_RD,    // read the head
    S_DSP_CHK,   // eligibility check and push
    S_DSP_SH,    // shift remaining entries down by one
    S_CMP_WR,    // restore the preempted priority
    S_DONE
  } state_t;

  state_t state;

  // architectural state
  logic [PRIO_W-1:0] running;
  logic [FILL_W-1:0] fill;
  logic [NL_W-1:0]   nest;
  logic [PRIO_W-1:0] saved [NEST_DEPTH];
  logic [PRIO_W-1:0] saved_rd;

  // per-request working registers
  logic [QA_W-1:0]     idx;
  logic [PRIO_W-1:0]   new_prio;
  logic [HANDLE_W-1:0] new_handle;
  logic [STATUS_W-1:0] res_status;
  logic                res_disp;
  logic [HANDLE_W-1:0] res_handle;
  logic [PRIO_W-1:0]   res_prio;

  // queue store
  qwr_t                qwr;
  logic [QA_W-1:0]     rd_addr;
  logic [PRIO_W-1:0]   rd_prio;
  logic [HANDLE_W-1:0] rd_handle;

  // shared comparator
  logic [PRIO_W-1:0] cmp_a;
  logic [PRIO_W-1:0] cmp_b;
  logic              cmp_gt;

  logic [NL_W-1:0] nest_m1;
  logic [NA_W-1:0] saved_raddr;
  logic            req_xfer;

  ppq_queue_mem u_queue (
    .clk       (clk),
    .wr        (qwr),
    .rd_addr   (rd_addr),
    .rd_prio   (rd_prio),
    .rd_handle (rd_handle)
  );

  assign request.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign req_xfer      = request.valid && request.ready;

  assign nest_m1     = nest - 1'b1;
  assign saved_raddr = nest_m1[NA_W-1:0];

  // one compare serves both the insertion walk and the dispatch check
  always_comb begin
    cmp_a = rd_prio;
    cmp_b = new_prio;
    if (state == S_DSP_CHK) begin
      cmp_a = running;
      cmp_b = rd_prio;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  // read address: the read for the next step goes out while this one is used
  always_comb begin
    case (state)
      S_ENQ_RD:   rd_addr = idx;
      S_ENQ_STEP: rd_addr = idx - 1'b1;
      S_DSP_CHK:  rd_addr = QA_W'(1);
      S_DSP_SH:   rd_addr = idx + 1'b1;
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    qwr = '0;
    case (state)
      S_ENQ_STEP: begin
        qwr.en   = 1'b1;
        qwr.addr = idx + 1'b1;
        if (cmp_gt) begin
          qwr.prio   = rd_prio;
          qwr.handle = rd_handle;
        end else begin
          qwr.prio   = new_prio;
          qwr.handle = new_handle;
        end
      end
      S_ENQ_INS: begin
        qwr.en     = 1'b1;
        qwr.addr   = '0;
        qwr.prio   = new_prio;
        qwr.handle = new_handle;
      end
      S_DSP_SH: begin
        qwr.en     = 1'b1;
        qwr.addr   = idx - 1'b1;
        qwr.prio   = rd_prio;
        qwr.handle = rd_handle;
      end
      default: qwr = '0;
    endcase
  end

  // nesting stack
  always_ff @(posedge clk) begin
    if (state == S_DSP_CHK && cmp_gt && nest != NL_W'(NEST_DEPTH)) begin
      saved[nest[NA_W-1:0]] <= running;
    end
    saved_rd <= saved[saved_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= IDLE_RESET;
      fill          <= '0;
      nest          <= '0;
      result.valid  <= 1'b0;
    end else begin
      // a new result in S_DONE takes the place of the one leaving
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end

      if (cfg.valid && cfg.ready) begin
        if (nest == '0) begin
          running <= cfg.data;
        end
      end

      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            new_prio   <= request.task_priority;
            new_handle <= request.task_handle;
            res_status <= ST_OK;
            res_disp   <= 1'b0;
            res_handle <= '0;
            res_prio   <= '0;
            case (request.func)
              FN_ENQ: begin
                if (fill == FILL_W'(QUEUE_DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else if (fill == '0) begin
                  state <= S_ENQ_INS;
                end else begin
                  idx   <= QA_W'(fill - 1'b1);
                  state <= S_ENQ_RD;
                end
              end
              FN_DISP: begin
                if (fill == '0) begin
                  res_status <= ST_NONE;
                  state      <= S_DONE;
                end else begin
                  state <= S_DSP_RD;
                end
              end
              FN_DONE: begin
                if (nest == '0) begin
                  res_status <= ST_UNDER;
                  state      <= S_DONE;
                end else begin
                  state <= S_CMP_WR;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_ENQ_RD: state <= S_ENQ_STEP;

        S_ENQ_STEP: begin
          if (cmp_gt) begin
            // entry moved up; keep walking towards the head
            if (idx == '0) begin
              state <= S_ENQ_INS;
            end else begin
              idx <= idx - 1'b1;
            end
          end else begin
            fill  <= fill + 1'b1;
            state <= S_DONE;
          end
        end

        S_ENQ_INS: begin
          fill  <= fill + 1'b1;
          state <= S_DONE;
        end

        S_DSP_RD: state <= S_DSP_CHK;

        S_DSP_CHK: begin
          if (!cmp_gt) begin
            res_status <= ST_NONE;
            state      <= S_DONE;
          end else if (nest == NL_W'(NEST_DEPTH)) begin
            res_status <= ST_OVER;
            state      <= S_DONE;
          end else begin
            res_disp   <= 1'b1;
            res_handle <= rd_handle;
            res_prio   <= rd_prio;
            running    <= rd_prio;
            nest       <= nest + 1'b1;
            fill       <= fill - 1'b1;
            idx        <= QA_W'(1);
            state      <= (fill == FILL_W'(1)) ? S_DONE : S_DSP_SH;
          end
        end

        S_DSP_SH: begin
          // fill already holds the count after the pop
          if (FILL_W'(idx) == fill) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_CMP_WR: begin
          running <= saved_rd;
          nest    <= nest_m1;
          state   <= S_DONE;
        end

        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid                <= 1'b1;
            result.status               <= res_status;
            result.dispatched           <= res_disp;
            result.out_handle           <= res_handle;
            result.out_priority         <= res_prio;
            result.running_priority_now <= running;
            result.pending_count        <= PEND_W'(fill);
            state                       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_nest_bound: assert property (@(posedge clk) disable iff (rst)
    nest <= NL_W'(NEST_DEPTH))
    else $error("nesting level beyond stack depth");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.dispatched |-> result.status == ST_OK)
    else $error("dispatch reported with a failure status");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.dispatched |->
      result.out_handle == '0 && result.out_priority == '0)
    else $error("task fields not cleared without dispatch");
`endif

endmodule

/* tb/tb_preemptive_priority_task_queue_unit.sv */
// Self-checking testbench of the preemptive priority task queue unit.
`timescale 1ns / 1ps

module tb_preemptive_priority_task_queue_unit;
  import ppq_pkg::*;

  // the one selector the block leaves unused
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                dispatched;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic [PRIO_W-1:0]   running;
    logic [PEND_W-1:0]   pending;
  } sched_outcome_t;

  logic clk;
  logic rst;

  ppq_req_if req_ch ();
  ppq_res_if res_ch ();
  ppq_cfg_if cfg_ch ();

  preemptive_priority_task_queue_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  // shadow of the scheduler state
  logic [PRIO_W-1:0]   q_prio   [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] q_handle [QUEUE_DEPTH];
  int                  q_fill = 0;
  logic [PRIO_W-1:0]   run_prio  = IDLE_RESET;
  logic [PRIO_W-1:0]   saved_prio [NEST_DEPTH];
  int                  nest = 0;

  sched_outcome_t sched_outcomes_q[$];
  int  fail_count  = 0;
  int  cycle_count = 0;
  int  hold_off_len = 0;   // long receiver hold-off, consumed by the ready process
  int  burst_left  = 0;
  bit  gaps_on     = 1'b1;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one operation of the scheduler; updates the shadow state
  function automatic sched_outcome_t sched_step(logic [FUNC_W-1:0] f,
                                                logic [HANDLE_W-1:0] h,
                                                logic [PRIO_W-1:0] p);
    sched_outcome_t o;
    int pos;
    o = '0;
    o.status = ST_OK;
    case (f)
      FN_ENQ: begin
        if (q_fill >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          pos = q_fill;
          // first strictly larger entry; equal priorities keep arrival order
          for (int k = 0; k < q_fill; k++) begin
            if (q_prio[k] > p) begin
              pos = k;
              break;
            end
          end
          for (int k = q_fill; k > pos; k--) begin
            q_prio[k]   = q_prio[k-1];
            q_handle[k] = q_handle[k-1];
          end
          q_prio[pos]   = p;
          q_handle[pos] = h;
          q_fill++;
        end
      end
      FN_DISP: begin
        if (q_fill == 0 || run_prio <= q_prio[0]) begin
          o.status = ST_NONE;
        end else if (nest >= NEST_DEPTH) begin
          o.status = ST_OVER;
        end else begin
          o.dispatched = 1'b1;
          o.handle     = q_handle[0];
          o.prio       = q_prio[0];
          for (int k = 1; k < q_fill; k++) begin
            q_prio[k-1]   = q_prio[k];
            q_handle[k-1] = q_handle[k];
          end
          q_fill--;
          saved_prio[nest] = run_prio;
          nest++;
          run_prio = o.prio;
        end
      end
      FN_DONE: begin
        if (nest == 0) begin
          o.status = ST_UNDER;
        end else begin
          nest--;
          run_prio = saved_prio[nest];
        end
      end
      default: begin
      end
    endcase
    o.running = run_prio;
    o.pending = q_fill[PEND_W-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [HANDLE_W-1:0] h,
                         input logic [PRIO_W-1:0] p);
    req_ch.valid         <= 1'b1;
    req_ch.func          <= f;
    req_ch.task_handle   <= h;
    req_ch.task_priority <= p;
    do @(posedge clk); while (!req_ch.ready);
    sched_outcomes_q.push_back(sched_step(f, h, p));
  endtask

  task automatic req_idle(input int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender in bursts while gaps_on: random gap, then a random run of back-to-back transfers
  task automatic offer_op(input logic [FUNC_W-1:0] f, input logic [HANDLE_W-1:0] h,
                          input logic [PRIO_W-1:0] p);
    if (gaps_on && burst_left == 0) begin
      req_idle($urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    send_op(f, h, p);
  endtask

  // hold the request side until every outstanding result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sched_outcomes_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_idle(input logic [PRIO_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    if (nest == 0) run_prio = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 4))
      0: p = PRIO_W'($urandom);
      1: p = PRIO_W'($urandom_range(0, 15));
      2: p = ($urandom_range(0, 1) != 0) ? '1 : '0;
      3: p = (run_prio > 64) ? PRIO_W'(run_prio - $urandom_range(1, 64))
                             : PRIO_W'($urandom_range(0, 63));
      default: p = run_prio;
    endcase
    return p;
  endfunction

  // random mix including the unused selector, biased towards preemption chains
  task automatic send_random_op();
    int r;
    logic [FUNC_W-1:0] f;
    r = $urandom_range(0, 99);
    if (r < 40)      f = FN_ENQ;
    else if (r < 70) f = FN_DISP;
    else if (r < 94) f = FN_DONE;
    else             f = FN_SPARE;
    offer_op(f, HANDLE_W'($urandom), pick_prio());
  endtask

  // ------------------------------------------------------------------ tests

  task automatic test_directed_ops();
    offer_op(FN_DONE,  8'h00, 16'h0000);  // completion with nothing running
    offer_op(FN_DISP,  8'hff, 16'hffff);  // dispatch from an empty queue
    offer_op(FN_SPARE, 8'hff, 16'hffff);  // unused selector
    offer_op(FN_ENQ,   8'h00, 16'h0000);
    offer_op(FN_ENQ,   8'hff, 16'hffff);
    offer_op(FN_ENQ,   8'ha5, IDLE_RESET);
    offer_op(FN_ENQ,   8'h5a, PRIO_W'(IDLE_RESET - 1));
    offer_op(FN_ENQ,   8'h11, PRIO_W'(IDLE_RESET - 1));  // equal priority, must follow 5a
    offer_op(FN_ENQ,   8'h22, 16'h0000);        // equal to the head, goes behind it
    offer_op(FN_DISP,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);  // head equal to running: not eligible
    offer_op(FN_DONE,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);
    offer_op(FN_DONE,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);
    offer_op(FN_DONE,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);
    offer_op(FN_DONE,  8'h00, 16'h0000);
    offer_op(FN_DISP,  8'h00, 16'h0000);  // head equals idle: nothing eligible
    offer_op(FN_SPARE, 8'h00, 16'h0000);
    drain();
  endtask

  task automatic test_idle_register();
    write_idle(16'hffff);
    offer_op(FN_DISP, 8'h00, 16'h0000);
    offer_op(FN_DISP, 8'h00, 16'h0000);
    drain();
    write_idle(16'h0000);  // nested: running priority must stay
    offer_op(FN_DISP, 8'h00, 16'h0000);
    offer_op(FN_DONE, 8'h00, 16'h0000);  // restores the saved value, not the register
    offer_op(FN_DISP, 8'h00, 16'h0000);
    drain();
    write_idle(16'h0000);
    offer_op(FN_ENQ,  8'h3c, 16'h0000);
    offer_op(FN_DISP, 8'h00, 16'h0000);
    drain();
    write_idle(16'hffff);
    offer_op(FN_DISP, 8'h00, 16'h0000);
    offer_op(FN_DONE, 8'h00, 16'h0000);
    drain();
    write_idle(IDLE_RESET);
  endtask

  task automatic test_queue_full();
    repeat (3) begin
      repeat (20) offer_op(FN_ENQ, HANDLE_W'($urandom), PRIO_W'($urandom));
      repeat (10) send_random_op();
    end
    drain();
  endtask

  // chains of ever more urgent tasks, past the nesting depth and back
  task automatic test_nest_limits();
    logic [PRIO_W-1:0] p;
    write_idle(16'hffff);
    repeat (3) begin
      p = run_prio;
      repeat (NEST_DEPTH + 2) begin
        p = (p > 600) ? PRIO_W'(p - $urandom_range(1, 500)) : p;
        offer_op(FN_ENQ, HANDLE_W'($urandom), p);
        offer_op(FN_DISP, HANDLE_W'($urandom), PRIO_W'($urandom));
      end
      repeat (NEST_DEPTH + 2) offer_op(FN_DONE, HANDLE_W'($urandom), PRIO_W'($urandom));
    end
    drain();
  endtask

  task automatic test_random_mix();
    logic [PRIO_W-1:0] idle_vals [5];
    idle_vals = '{16'h0000, 16'hffff, 16'h0000, IDLE_RESET, 16'h0000};
    idle_vals[2] = PRIO_W'($urandom);
    idle_vals[4] = PRIO_W'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      gaps_on = (ph != 2);  // one phase with no idling on the sender
      repeat (140) send_random_op();
      drain();  // sender pauses until all results are back
      write_idle(idle_vals[ph]);
    end
    gaps_on = 1'b1;
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    gaps_on = 1'b0;
    @(posedge clk);
    hold_off_len = 300;
    repeat (40) send_random_op();
    gaps_on = 1'b1;
    drain();
  endtask

  // ------------------------------------------------------------ result side

  // receiver stalls: segments of random mode, plus the long hold-off on request
  initial begin
    int mode;
    int seg;
    int n;
    int tick;
    mode = 0;
    seg  = 0;
    tick = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(5, 60);
      end
      seg--;
      tick++;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (tick % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    sched_outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sched_outcomes_q.size() == 0) begin
        $display("%0t ERROR: result with none outstanding, status %0d", $time,
                 res_ch.status);
        fail_count++;
      end else begin
        want = sched_outcomes_q.pop_front();
        if (res_ch.status !== want.status) begin
          $display("%0t ERROR: status exp %0d got %0d", $time, want.status,
                   res_ch.status);
          fail_count++;
        end
        if (res_ch.dispatched !== want.dispatched) begin
          $display("%0t ERROR: dispatched exp %0d got %0d", $time, want.dispatched,
                   res_ch.dispatched);
          fail_count++;
        end
        if (res_ch.out_handle !== want.handle) begin
          $display("%0t ERROR: out_handle exp %0h got %0h", $time, want.handle,
                   res_ch.out_handle);
          fail_count++;
        end
        if (res_ch.out_priority !== want.prio) begin
          $display("%0t ERROR: out_priority exp %0d got %0d", $time, want.prio,
                   res_ch.out_priority);
          fail_count++;
        end
        if (res_ch.running_priority_now !== want.running) begin
          $display("%0t ERROR: running_priority_now exp %0d got %0d", $time,
                   want.running, res_ch.running_priority_now);
          fail_count++;
        end
        if (res_ch.pending_count !== want.pending) begin
          $display("%0t ERROR: pending_count exp %0d got %0d", $time, want.pending,
                   res_ch.pending_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ------------------------------------------------------------------- main

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.func          <= FN_ENQ;
    req_ch.task_handle   <= '0;
    req_ch.task_priority <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.data          <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_idle_register();
    test_queue_full();
    test_nest_limits();
    test_random_mix();
    test_backpressure();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ppq_pkg.sv
rtl/core/ppq_channels.sv
rtl/core/ppq_queue_mem.sv
rtl/core/preemptive_priority_task_queue_unit.sv
tb/tb_preemptive_priority_task_queue_unit.sv
